@@ rtl/core/matrix3x3_inverse_defines.svh @@
// Assertion macros shared by the matrix inverse checker.
`ifndef MATRIX3X3_INVERSE_DEFINES_SVH
`define MATRIX3X3_INVERSE_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define M3INV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define M3INV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/m3inv_pkg.sv @@
// Types, constants and tables shared by the 3x3 matrix inverse block.
`timescale 1ns / 1ps
`default_nettype none

package m3inv_pkg;

    // Stored matrix geometry
    localparam int STORE_DEPTH = 9;
    localparam int IDX_W = 4;
    localparam int VALUE_W = 32;
    localparam logic [1:0] MAX_INDEX = 2'd2;
    localparam logic [IDX_W-1:0] LAST_ITEM = 4'd8;

    // Input transfer payload
    typedef struct packed {
        logic [1:0] row;
        logic [1:0] col;
        logic signed [VALUE_W-1:0] value;
        logic last_element;
    } elem_item_t;

    // Result transfer payload
    typedef struct packed {
        logic [1:0] out_row;
        logic [1:0] out_col;
        logic signed [VALUE_W-1:0] out_value;
        logic singular;
        logic saturated;
        logic last_result;
    } inv_item_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COF,
        ST_DET,
        ST_PREP,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_DIV_OUT
    } state_t;

    // Second multiplier operand source
    typedef enum logic [1:0] {
        B_ELEM,
        B_COF_LO,
        B_COF_HI
    } b_src_t;

    // Accumulator operation
    typedef enum logic [1:0] {
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    // Multiply-accumulate command, carried down the MAC pipeline
    typedef struct packed {
        logic mul_en;
        logic [IDX_W-1:0] a_idx;
        logic [IDX_W-1:0] b_idx;
        b_src_t b_src;
        acc_op_t acc_op;
        logic acc_shift;
        logic wr_cof;
        logic [IDX_W-1:0] cof_idx;
    } mul_cmd_t;

    // Controller to datapath
    typedef struct packed {
        logic accept_en;
        mul_cmd_t mul;
        logic det_prep;
        logic div_load;
        logic div_step;
        logic out_load;
        logic [IDX_W-1:0] item_idx;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic start;
        logic singular;
        logic out_free;
    } dp_status_t;

    // Element indexes of the two products of one cofactor: P = p_a*p_b, Q = q_a*q_b
    typedef struct packed {
        logic [IDX_W-1:0] p_a;
        logic [IDX_W-1:0] p_b;
        logic [IDX_W-1:0] q_a;
        logic [IDX_W-1:0] q_b;
    } cof_ops_t;

    localparam cof_ops_t COF_OPS [STORE_DEPTH] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd7, 4'd2, 4'd8, 4'd1},
        '{4'd8, 4'd0, 4'd6, 4'd2},
        '{4'd6, 4'd1, 4'd7, 4'd0},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    // Transposed cofactor feeding each result, and the result position
    localparam logic [IDX_W-1:0] NUM_IDX [STORE_DEPTH] = '{
        4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8
    };
    localparam logic [1:0] OUT_ROW [STORE_DEPTH] = '{
        2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2
    };
    localparam logic [1:0] OUT_COL [STORE_DEPTH] = '{
        2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2
    };

    // Row-major element index
    function automatic logic [IDX_W-1:0] elem_index(input logic [1:0] r, input logic [1:0] c);
        return IDX_W'({r, 1'b0}) + IDX_W'(r) + IDX_W'(c);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/m3inv_chan_if.sv @@
// Valid/ready channel carrying one payload per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface m3inv_chan_if #(parameter type payload_t = logic) ();
    logic valid;
    logic ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/m3inv_ram.sv @@
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module m3inv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 9
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

@@ rtl/core/m3inv_ctrl.sv @@
// Sequencer for loading, cofactor/determinant MAC steps and the shared divider.
`timescale 1ns / 1ps
`default_nettype none

module m3inv_ctrl #(
    parameter int FRAC_BITS = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    output m3inv_pkg::dp_cmd_t     cmd,
    input  m3inv_pkg::dp_status_t  status
);

    localparam int NMW = 2 * ELEMENT_WIDTH + 2 * FRAC_BITS;
    localparam int BCW = $clog2(NMW);
    localparam logic [4:0] COF_LAST_MUL = 5'd17;
    localparam logic [4:0] COF_LAST_STEP = 5'd19;
    localparam logic [4:0] DET_LAST_MUL = 5'd5;
    localparam logic [4:0] DET_LAST_STEP = 5'd7;

    m3inv_pkg::state_t state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic [m3inv_pkg::IDX_W-1:0] item_reg, item_next;
    logic [BCW-1:0] bit_reg, bit_next;

    m3inv_pkg::cof_ops_t ops;
    logic [m3inv_pkg::IDX_W-1:0] cof_k;

    assign cof_k = step_reg[4:1];
    assign ops = m3inv_pkg::COF_OPS[cof_k];

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= m3inv_pkg::ST_IDLE;
            step_reg  <= '0;
            item_reg  <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            item_reg  <= item_next;
            bit_reg   <= bit_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        item_next  = item_reg;
        bit_next   = bit_reg;
        cmd        = '0;
        cmd.item_idx = item_reg;

        case (state_reg)
            m3inv_pkg::ST_IDLE:
            begin
                cmd.accept_en = 1'b1;
                if (status.start)
                begin
                    state_next = m3inv_pkg::ST_COF;
                    step_next  = '0;
                end
            end

            // Two products per cofactor, then let the MAC pipeline drain
            m3inv_pkg::ST_COF:
            begin
                if (step_reg <= COF_LAST_MUL)
                begin
                    cmd.mul.mul_en  = 1'b1;
                    cmd.mul.b_src   = m3inv_pkg::B_ELEM;
                    cmd.mul.cof_idx = cof_k;
                    if (!step_reg[0])
                    begin
                        cmd.mul.a_idx  = ops.p_a;
                        cmd.mul.b_idx  = ops.p_b;
                        cmd.mul.acc_op = m3inv_pkg::ACC_LOAD;
                    end
                    else
                    begin
                        cmd.mul.a_idx  = ops.q_a;
                        cmd.mul.b_idx  = ops.q_b;
                        cmd.mul.acc_op = m3inv_pkg::ACC_SUB;
                        cmd.mul.wr_cof = 1'b1;
                    end
                end
                if (step_reg == COF_LAST_STEP)
                begin
                    state_next = m3inv_pkg::ST_DET;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end

            // Expand along row 0, cofactor low half then high half
            m3inv_pkg::ST_DET:
            begin
                if (step_reg <= DET_LAST_MUL)
                begin
                    cmd.mul.mul_en    = 1'b1;
                    cmd.mul.a_idx     = {2'b00, step_reg[2:1]};
                    cmd.mul.b_idx     = {2'b00, step_reg[2:1]};
                    cmd.mul.b_src     = step_reg[0] ? m3inv_pkg::B_COF_HI : m3inv_pkg::B_COF_LO;
                    cmd.mul.acc_op    = (step_reg == '0) ? m3inv_pkg::ACC_LOAD
                                                         : m3inv_pkg::ACC_ADD;
                    cmd.mul.acc_shift = step_reg[0];
                end
                if (step_reg == DET_LAST_STEP)
                begin
                    state_next = m3inv_pkg::ST_PREP;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end

            m3inv_pkg::ST_PREP:
            begin
                cmd.det_prep = 1'b1;
                item_next    = '0;
                state_next   = m3inv_pkg::ST_DIV_LOAD;
            end

            m3inv_pkg::ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                bit_next     = BCW'(NMW - 1);
                state_next   = status.singular ? m3inv_pkg::ST_DIV_OUT : m3inv_pkg::ST_DIV_RUN;
            end

            // One quotient bit per cycle
            m3inv_pkg::ST_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                if (bit_reg == '0)
                begin
                    state_next = m3inv_pkg::ST_DIV_OUT;
                end
                else
                begin
                    bit_next = bit_reg - BCW'(1);
                end
            end

            // Hand the result to the output register once it is free
            m3inv_pkg::ST_DIV_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (item_reg == m3inv_pkg::LAST_ITEM)
                    begin
                        state_next = m3inv_pkg::ST_IDLE;
                    end
                    else
                    begin
                        item_next  = item_reg + 4'd1;
                        state_next = m3inv_pkg::ST_DIV_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = m3inv_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/m3inv_dpath.sv @@
// Datapath: matrix store, MAC pipeline, cofactor registers, divider, output register.
`timescale 1ns / 1ps
`default_nettype none

module m3inv_dpath #(
    parameter int FRAC_BITS = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    m3inv_chan_if.sink            elem_ch,
    m3inv_chan_if.source          inv_ch,
    input  m3inv_pkg::dp_cmd_t    cmd,
    output m3inv_pkg::dp_status_t status
);

    localparam int EW = ELEMENT_WIDTH;
    localparam int CW = 2 * EW + 1;
    localparam int PW = 2 * EW + 1;
    localparam int AW = 3 * EW + 1;
    localparam int DMW = 3 * EW;
    localparam int MAGW = 2 * EW;
    localparam int NMW = 2 * EW + 2 * FRAC_BITS;
    localparam int SHIFT = 2 * FRAC_BITS;
    localparam int IW = m3inv_pkg::IDX_W;
    localparam int DEPTH = m3inv_pkg::STORE_DEPTH;

    // Element loading
    logic in_xfer;
    logic store_we;
    logic [IW-1:0] store_waddr;
    logic [DEPTH-1:0] store_valid_reg;

    assign elem_ch.ready = cmd.accept_en;
    assign in_xfer = elem_ch.valid & cmd.accept_en;
    assign store_we = in_xfer && (elem_ch.data.row <= m3inv_pkg::MAX_INDEX)
                      && (elem_ch.data.col <= m3inv_pkg::MAX_INDEX);
    assign store_waddr = m3inv_pkg::elem_index(elem_ch.data.row, elem_ch.data.col);

    // Mark written entries; unwritten ones read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_valid_reg <= '0;
        end
        else if (store_we)
        begin
            store_valid_reg[store_waddr] <= 1'b1;
        end
    end

    logic [EW-1:0] rd_a, rd_b;

    m3inv_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (store_we),
        .waddr   (store_waddr),
        .wdata   (elem_ch.data.value[EW-1:0]),
        .raddr_a (cmd.mul.a_idx),
        .raddr_b (cmd.mul.b_idx),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // MAC pipeline control
    m3inv_pkg::mul_cmd_t mul1_reg, mul2_reg;
    logic va1_reg, vb1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul1_reg <= '0;
            mul2_reg <= '0;
            va1_reg  <= 1'b0;
            vb1_reg  <= 1'b0;
        end
        else
        begin
            mul1_reg <= cmd.mul;
            mul2_reg <= mul1_reg;
            va1_reg  <= store_valid_reg[cmd.mul.a_idx];
            vb1_reg  <= store_valid_reg[cmd.mul.b_idx];
        end
    end

    // Cofactor registers, one read address
    logic signed [CW-1:0] cof_reg [DEPTH];
    logic [IW-1:0] cof_rd_idx;
    logic signed [CW-1:0] cof_rd;

    assign cof_rd_idx = cmd.div_load ? m3inv_pkg::NUM_IDX[cmd.item_idx] : mul1_reg.b_idx;
    assign cof_rd = cof_reg[cof_rd_idx];

    // Select operands and multiply
    logic signed [EW-1:0] a_op;
    logic signed [EW:0] b_op;
    logic signed [PW-1:0] prod_reg;

    always_comb
    begin
        a_op = va1_reg ? signed'(rd_a) : '0;
        case (mul1_reg.b_src)
            m3inv_pkg::B_ELEM:   b_op = vb1_reg ? signed'({rd_b[EW-1], rd_b}) : '0;
            m3inv_pkg::B_COF_LO: b_op = signed'({1'b0, cof_rd[EW-1:0]});
            m3inv_pkg::B_COF_HI: b_op = signed'(cof_rd[CW-1:EW]);
            default:             b_op = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_op * b_op;
    end

    // Accumulate and store cofactors
    logic signed [AW-1:0] acc_reg, acc_next, prod_ext, addend;

    always_comb
    begin
        prod_ext = AW'(prod_reg);
        addend   = mul2_reg.acc_shift ? (prod_ext <<< EW) : prod_ext;
        case (mul2_reg.acc_op)
            m3inv_pkg::ACC_LOAD: acc_next = addend;
            m3inv_pkg::ACC_ADD:  acc_next = acc_reg + addend;
            m3inv_pkg::ACC_SUB:  acc_next = acc_reg - addend;
            default:             acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mul2_reg.mul_en)
        begin
            acc_reg <= acc_next;
            if (mul2_reg.wr_cof)
            begin
                cof_reg[mul2_reg.cof_idx] <= acc_next[CW-1:0];
            end
        end
    end

    // Determinant sign and magnitude
    logic [AW-1:0] det_abs;
    logic [DMW-1:0] det_mag_reg;
    logic det_neg_reg;
    logic singular_reg;

    assign det_abs = acc_reg[AW-1] ? AW'(-acc_reg) : AW'(acc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            singular_reg <= 1'b0;
        end
        else if (cmd.det_prep)
        begin
            singular_reg <= (acc_reg == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.det_prep)
        begin
            det_mag_reg <= det_abs[DMW-1:0];
            det_neg_reg <= acc_reg[AW-1];
        end
    end

    // Restoring divider, one quotient bit per step
    logic [CW-1:0] cof_abs;
    logic [NMW-1:0] num_sh_reg;
    logic [DMW-1:0] rem_reg, rem_next;
    logic [EW-1:0] q_reg;
    logic ovf_reg;
    logic num_neg_reg;
    logic [DMW:0] trial;
    logic [DMW+1:0] diff;
    logic ge;

    assign cof_abs = cof_rd[CW-1] ? CW'(-cof_rd) : CW'(cof_rd);
    assign trial = {rem_reg, num_sh_reg[NMW-1]};
    assign diff = {1'b0, trial} - {2'b00, det_mag_reg};
    assign ge = ~diff[DMW+1];
    assign rem_next = ge ? diff[DMW-1:0] : trial[DMW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            num_sh_reg  <= NMW'(cof_abs[MAGW-1:0]) << SHIFT;
            num_neg_reg <= cof_rd[CW-1];
            rem_reg     <= '0;
            q_reg       <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (cmd.div_step)
        begin
            num_sh_reg <= num_sh_reg << 1;
            rem_reg    <= rem_next;
            q_reg      <= {q_reg[EW-2:0], ge};
            ovf_reg    <= ovf_reg | q_reg[EW-1];
        end
    end

    // Sign, saturate and form the result
    logic res_neg;
    logic [EW-1:0] lim;
    logic res_sat;
    logic [EW-1:0] q_clip;
    logic signed [EW-1:0] res_val;
    m3inv_pkg::inv_item_t res_item;

    always_comb
    begin
        res_neg = num_neg_reg ^ det_neg_reg;
        lim     = res_neg ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
        res_sat = ovf_reg || (q_reg > lim);
        q_clip  = res_sat ? lim : q_reg;
        res_val = res_neg ? signed'(-q_clip) : signed'(q_clip);

        res_item.out_row     = m3inv_pkg::OUT_ROW[cmd.item_idx];
        res_item.out_col     = m3inv_pkg::OUT_COL[cmd.item_idx];
        res_item.last_result = (cmd.item_idx == m3inv_pkg::LAST_ITEM);
        if (singular_reg)
        begin
            res_item.out_value = '0;
            res_item.singular  = 1'b1;
            res_item.saturated = 1'b0;
        end
        else
        begin
            res_item.out_value = m3inv_pkg::VALUE_W'(res_val);
            res_item.singular  = 1'b0;
            res_item.saturated = res_sat;
        end
    end

    // Output register
    logic out_valid_reg;
    m3inv_pkg::inv_item_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (inv_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= res_item;
        end
    end

    assign inv_ch.valid = out_valid_reg;
    assign inv_ch.data  = out_data_reg;

    // Status back to the controller
    assign status.start    = in_xfer & elem_ch.data.last_element;
    assign status.singular = singular_reg;
    assign status.out_free = ~out_valid_reg | inv_ch.ready;

endmodule

`default_nettype wire

@@ rtl/core/matrix3x3_inverse.sv @@
// Top level of the 3x3 fixed-point matrix inverse.
`timescale 1ns / 1ps
`default_nettype none

// Elements are loaded one per cycle on elem_ch (row, col, value); a transfer
// with last_element set writes its element and starts the inversion of the
// stored matrix, and elem_ch stays not ready until all nine results have been
// handed to the output register. The run computes the nine cofactors and then
// the determinant on one shared EW x (EW+1) multiplier, takes the determinant
// magnitude, then forms each result on the single radix-2 restoring divider
// that all nine quotients share, with a dividend of NMW = 2*ELEMENT_WIDTH +
// 2*FRAC_BITS bits; stalls on inv_ch hold the run. A singular matrix skips
// the divider. Results come out row-major on inv_ch through a one-entry
// output register; the matrix store keeps its contents between runs.
module matrix3x3_inverse #(
    parameter int FRAC_BITS = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    m3inv_chan_if.sink    elem_ch,
    m3inv_chan_if.source  inv_ch
);

    m3inv_pkg::dp_cmd_t    cmd;
    m3inv_pkg::dp_status_t status;

    // Sequencer
    m3inv_ctrl #(
        .FRAC_BITS     (FRAC_BITS),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status)
    );

    // Arithmetic and storage
    m3inv_dpath #(
        .FRAC_BITS     (FRAC_BITS),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .elem_ch (elem_ch),
        .inv_ch  (inv_ch),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

`default_nettype wire

@@ rtl/core/m3inv_checker.sv @@
// Port-level checks for the matrix inverse, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "matrix3x3_inverse_defines.svh"

module m3inv_port_props (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_row,
    input logic [1:0]  out_col,
    input logic [31:0] out_value,
    input logic        out_singular,
    input logic        out_saturated,
    input logic        out_last
);

    // Hold a stalled result
    `M3INV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_value) && $stable(out_row) && $stable(out_col),
        "stalled result changed")

    // Drop input ready once a run starts
    `M3INV_ASSERT_NEXT(a_busy_after_start, in_valid && in_ready && in_last,
        !in_ready, "input taken while computing")

    // Singular results carry zero and no clip
    `M3INV_ASSERT_NOW(a_singular_zero, out_valid && out_singular,
        out_value == 32'd0 && !out_saturated, "singular result not zero")

    // Mark the bottom-right element, and only it, as the final one
    `M3INV_ASSERT_NOW(a_last_corner, out_valid,
        out_last == (out_row == 2'd2 && out_col == 2'd2), "final result flag misplaced")

endmodule

bind matrix3x3_inverse m3inv_port_props u_m3inv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (elem_ch.valid),
    .in_ready      (elem_ch.ready),
    .in_last       (elem_ch.data.last_element),
    .out_valid     (inv_ch.valid),
    .out_ready     (inv_ch.ready),
    .out_row       (inv_ch.data.out_row),
    .out_col       (inv_ch.data.out_col),
    .out_value     (inv_ch.data.out_value),
    .out_singular  (inv_ch.data.singular),
    .out_saturated (inv_ch.data.saturated),
    .out_last      (inv_ch.data.last_result)
);

`default_nettype wire
